FILE: design/gkm_pkg.sv
package gkm_pkg;

    // event types
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_ABS = 5'd3;

    // first button code
    localparam logic [9:0] BTN_BASE = 10'h100;

    // axis codes
    localparam logic [9:0] AXIS_X     = 10'h000;
    localparam logic [9:0] AXIS_Y     = 10'h001;
    localparam logic [9:0] AXIS_RX    = 10'h003;
    localparam logic [9:0] AXIS_RY    = 10'h004;
    localparam logic [9:0] AXIS_HAT_X = 10'h010;
    localparam logic [9:0] AXIS_HAT_Y = 10'h011;

    // axis slots
    localparam logic [2:0] SLOT_X     = 3'd0;
    localparam logic [2:0] SLOT_Y     = 3'd1;
    localparam logic [2:0] SLOT_RX    = 3'd2;
    localparam logic [2:0] SLOT_RY    = 3'd3;
    localparam logic [2:0] SLOT_HAT0X = 3'd4;
    localparam logic [2:0] SLOT_HAT0Y = 3'd5;
    localparam int         NUM_SLOTS  = 6;

    // configuration register indexes
    localparam logic [2:0] REG_LEFT_MIN  = 3'd0;
    localparam logic [2:0] REG_LEFT_MAX  = 3'd1;
    localparam logic [2:0] REG_RIGHT_MIN = 3'd2;
    localparam logic [2:0] REG_RIGHT_MAX = 3'd3;
    localparam logic [2:0] REG_HAT_MIN   = 3'd4;
    localparam logic [2:0] REG_HAT_MAX   = 3'd5;

    // axis directions
    localparam logic [1:0] DIR_CENTRE = 2'd0;
    localparam logic [1:0] DIR_NEG    = 2'd1;
    localparam logic [1:0] DIR_POS    = 2'd2;

    // keyboard key codes
    localparam logic [7:0] KC_ESC       = 8'd1;
    localparam logic [7:0] KC_BACKSPACE = 8'd14;
    localparam logic [7:0] KC_ENTER     = 8'd28;
    localparam logic [7:0] KC_LSHIFT    = 8'd42;
    localparam logic [7:0] KC_Z         = 8'd44;
    localparam logic [7:0] KC_X         = 8'd45;
    localparam logic [7:0] KC_C         = 8'd46;
    localparam logic [7:0] KC_UP        = 8'd103;
    localparam logic [7:0] KC_LEFT      = 8'd105;
    localparam logic [7:0] KC_RIGHT     = 8'd106;
    localparam logic [7:0] KC_DOWN      = 8'd108;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_KEY  = 2'd1,
        KIND_AXIS = 2'd2
    } kind_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
    } slot_t;

    // up to two key events: an optional release, then an optional press or button event
    typedef struct packed {
        logic       ev0_valid;
        logic [7:0] ev0_key;
        logic       ev0_down;
        logic       ev1_valid;
        logic [7:0] ev1_key;
        logic       ev1_down;
    } cmd_t;

    function automatic logic [7:0] button_key(input logic [9:0] code);
        logic [7:0] k;
        case (code)
            10'h131: k = KC_ESC;
            10'h133: k = KC_Z;
            10'h134: k = KC_X;
            10'h136: k = KC_LSHIFT;
            10'h137: k = KC_C;
            10'h13a: k = KC_BACKSPACE;
            10'h121: k = KC_Z;
            10'h122: k = KC_X;
            10'h123: k = KC_ESC;
            10'h125: k = KC_Z;
            10'h127: k = KC_ESC;
            10'h128: k = KC_LSHIFT;
            10'h129: k = KC_C;
            10'h12a: k = KC_BACKSPACE;
            default: k = KC_ENTER;
        endcase
        return k;
    endfunction

    function automatic slot_t axis_slot(input logic [9:0] code);
        slot_t s;
        s.hit = 1'b1;
        case (code)
            AXIS_X:     s.slot = SLOT_X;
            AXIS_Y:     s.slot = SLOT_Y;
            AXIS_RX:    s.slot = SLOT_RX;
            AXIS_RY:    s.slot = SLOT_RY;
            AXIS_HAT_X: s.slot = SLOT_HAT0X;
            AXIS_HAT_Y: s.slot = SLOT_HAT0Y;
            default:
            begin
                s.hit  = 1'b0;
                s.slot = SLOT_X;
            end
        endcase
        return s;
    endfunction

endpackage

FILE: design/gamepad_to_key_event_mapper.sv
// Gamepad event to keyboard key event mapper. One input item per cycle, while
// s_tready is high, enters a four-stage front that classifies it, computes the
// axis zone edges from the selected range pair and updates the per-axis
// direction; a queue of QUEUE_DEPTH commands then feeds a back end that drives
// one key event per cycle, while the receiver accepts, into the output register.
// A button item gives one key event and an axis item whose zone changes gives one
// or two; items that produce nothing never enter the queue. An accepted item
// passes the stage 1 to 3 registers and the queue before it reaches the output
// register. s_tready drops while the queue plus the items in the front would
// fill the queue. cfg_ready is always high; write ranges only while idle.
// Direction state resets to centre on all axes with no clearing pass.
module gamepad_to_key_event_mapper #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // event_type[4:0], event_code[14:5], event_value[46:15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // key_code[7:0]
    output logic        m_tuser,   // down[0]
    output logic        m_tlast    // last_of_run
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             push, pop, head_valid;
    gkm_pkg::cmd_t    push_cmd, head_cmd;
    logic [CNT_W-1:0] q_count;

    gkm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_count   (q_count),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    gkm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .count      (q_count)
    );

    gkm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: design/gkm_front.sv
module gkm_front #(
    parameter int DEPTH = 8,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic [CNT_W-1:0]  q_count,
    output logic              push,
    output gkm_pkg::cmd_t     push_cmd
);

    logic [31:0] left_min_reg, left_max_reg;
    logic [31:0] right_min_reg, right_max_reg;
    logic [31:0] hat_min_reg, hat_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_min_reg  <= 32'd0;
            left_max_reg  <= 32'd255;
            right_min_reg <= 32'd0;
            right_max_reg <= 32'd255;
            hat_min_reg   <= 32'd0;
            hat_max_reg   <= 32'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gkm_pkg::REG_LEFT_MIN:  left_min_reg  <= cfg_data;
                gkm_pkg::REG_LEFT_MAX:  left_max_reg  <= cfg_data;
                gkm_pkg::REG_RIGHT_MIN: right_min_reg <= cfg_data;
                gkm_pkg::REG_RIGHT_MAX: right_max_reg <= cfg_data;
                gkm_pkg::REG_HAT_MIN:   hat_min_reg   <= cfg_data;
                gkm_pkg::REG_HAT_MAX:   hat_max_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    logic [4:0]  in_type;
    logic [9:0]  in_code;
    logic [31:0] in_value;
    assign in_type  = s_tdata[4:0];
    assign in_code  = s_tdata[14:5];
    assign in_value = s_tdata[46:15];

    logic p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [1:0] inflight;
    logic accept;

    // reserve queue room for every item still in the pipeline
    assign inflight = {1'b0, p1_valid_reg} + {1'b0, p2_valid_reg} + {1'b0, p3_valid_reg};
    assign s_tready = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(inflight))
                      < (CNT_W + 1)'(DEPTH);
    assign accept   = s_tvalid && s_tready;

    // classify
    gkm_pkg::slot_t in_slot;
    gkm_pkg::kind_t in_kind;
    logic [31:0] sel_lo, sel_hi;
    logic [32:0] span_raw;

    always_comb
    begin
        in_slot = gkm_pkg::axis_slot(in_code);
        if (in_type == gkm_pkg::EV_KEY && in_code >= gkm_pkg::BTN_BASE
            && (in_value == 32'd0 || in_value == 32'd1))
            in_kind = gkm_pkg::KIND_KEY;
        else if (in_type == gkm_pkg::EV_ABS && in_slot.hit)
            in_kind = gkm_pkg::KIND_AXIS;
        else
            in_kind = gkm_pkg::KIND_NONE;

        case (in_slot.slot)
            gkm_pkg::SLOT_X, gkm_pkg::SLOT_Y:
            begin
                sel_lo = left_min_reg;
                sel_hi = left_max_reg;
            end
            gkm_pkg::SLOT_RX, gkm_pkg::SLOT_RY:
            begin
                sel_lo = right_min_reg;
                sel_hi = right_max_reg;
            end
            default:
            begin
                sel_lo = hat_min_reg;
                sel_hi = hat_max_reg;
            end
        endcase
        span_raw = {sel_hi[31], sel_hi} - {sel_lo[31], sel_lo};
    end

    // stage 1: sum and span
    gkm_pkg::kind_t p1_kind_reg;
    logic [2:0]  p1_slot_reg;
    logic [31:0] p1_value_reg;
    logic [7:0]  p1_key_reg;
    logic        p1_down_reg;
    logic [32:0] p1_sum_reg, p1_span_reg;

    // stage 2: midpoint and quarter span
    gkm_pkg::kind_t p2_kind_reg;
    logic [2:0]  p2_slot_reg;
    logic [31:0] p2_value_reg;
    logic [7:0]  p2_key_reg;
    logic        p2_down_reg;
    logic [32:0] p2_mid_reg, p2_q_reg;

    // stage 3: zone edges
    gkm_pkg::kind_t p3_kind_reg;
    logic [2:0]  p3_slot_reg;
    logic [31:0] p3_value_reg;
    logic [7:0]  p3_key_reg;
    logic        p3_down_reg;
    logic [33:0] p3_lo_th_reg, p3_hi_th_reg;

    logic [32:0] mid_tmp, q_tmp;
    logic [32:0] mid_next, q_next;

    always_comb
    begin
        // truncate toward zero: bias negative values before the shift
        mid_tmp  = p1_sum_reg + {32'd0, p1_sum_reg[32]};
        mid_next = {mid_tmp[32], mid_tmp[32:1]};
        q_tmp    = p1_span_reg + (p1_span_reg[32] ? 33'd3 : 33'd0);
        q_next   = {{2{q_tmp[32]}}, q_tmp[32:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_kind_reg  <= in_kind;
        p1_slot_reg  <= in_slot.slot;
        p1_value_reg <= in_value;
        p1_key_reg   <= gkm_pkg::button_key(in_code);
        p1_down_reg  <= in_value[0];
        p1_sum_reg   <= {sel_lo[31], sel_lo} + {sel_hi[31], sel_hi};
        p1_span_reg  <= (span_raw == 33'd0) ? 33'd255 : span_raw;

        p2_kind_reg  <= p1_kind_reg;
        p2_slot_reg  <= p1_slot_reg;
        p2_value_reg <= p1_value_reg;
        p2_key_reg   <= p1_key_reg;
        p2_down_reg  <= p1_down_reg;
        p2_mid_reg   <= mid_next;
        p2_q_reg     <= q_next;

        p3_kind_reg  <= p2_kind_reg;
        p3_slot_reg  <= p2_slot_reg;
        p3_value_reg <= p2_value_reg;
        p3_key_reg   <= p2_key_reg;
        p3_down_reg  <= p2_down_reg;
        p3_lo_th_reg <= {p2_mid_reg[32], p2_mid_reg} - {p2_q_reg[32], p2_q_reg};
        p3_hi_th_reg <= {p2_mid_reg[32], p2_mid_reg} + {p2_q_reg[32], p2_q_reg};
    end

    // stage 4: zone, direction update, command
    logic [1:0] dir_reg [gkm_pkg::NUM_SLOTS];
    logic [33:0] value_ext;
    logic [1:0]  new_dir, old_dir;
    logic [7:0]  key_neg, key_pos;
    logic        changed;

    always_comb
    begin
        value_ext = {{2{p3_value_reg[31]}}, p3_value_reg};
        if ($signed(value_ext) <= $signed(p3_lo_th_reg))
            new_dir = gkm_pkg::DIR_NEG;
        else if ($signed(value_ext) >= $signed(p3_hi_th_reg))
            new_dir = gkm_pkg::DIR_POS;
        else
            new_dir = gkm_pkg::DIR_CENTRE;

        old_dir = (p3_slot_reg < 3'(gkm_pkg::NUM_SLOTS)) ? dir_reg[p3_slot_reg]
                                                         : gkm_pkg::DIR_CENTRE;
        // odd slots are vertical axes
        key_neg = p3_slot_reg[0] ? gkm_pkg::KC_UP   : gkm_pkg::KC_LEFT;
        key_pos = p3_slot_reg[0] ? gkm_pkg::KC_DOWN : gkm_pkg::KC_RIGHT;
        changed = (new_dir != old_dir);

        push_cmd = '0;
        push     = 1'b0;
        case (p3_kind_reg)
            gkm_pkg::KIND_KEY:
            begin
                push               = p3_valid_reg;
                push_cmd.ev1_valid = 1'b1;
                push_cmd.ev1_key   = p3_key_reg;
                push_cmd.ev1_down  = p3_down_reg;
            end
            gkm_pkg::KIND_AXIS:
            begin
                push               = p3_valid_reg && changed;
                push_cmd.ev0_valid = (old_dir != gkm_pkg::DIR_CENTRE);
                push_cmd.ev0_key   = (old_dir == gkm_pkg::DIR_NEG) ? key_neg : key_pos;
                push_cmd.ev0_down  = 1'b0;
                push_cmd.ev1_valid = (new_dir != gkm_pkg::DIR_CENTRE);
                push_cmd.ev1_key   = (new_dir == gkm_pkg::DIR_NEG) ? key_neg : key_pos;
                push_cmd.ev1_down  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gkm_pkg::NUM_SLOTS; i++)
                dir_reg[i] <= gkm_pkg::DIR_CENTRE;
        end
        else if (p3_valid_reg && p3_kind_reg == gkm_pkg::KIND_AXIS && changed)
        begin
            dir_reg[p3_slot_reg] <= new_dir;
        end
    end

endmodule

FILE: design/gkm_queue.sv
module gkm_queue #(
    parameter int DEPTH = 8,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gkm_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output logic              head_valid,
    output gkm_pkg::cmd_t     head_cmd,
    output logic [CNT_W-1:0]  count
);

    gkm_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/gkm_back.sv
module gkm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  gkm_pkg::cmd_t  head_cmd,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);

    logic       m_tvalid_reg;
    logic [7:0] key_reg;
    logic       down_reg, last_reg;
    logic       phase_reg;
    logic       load, use_ev0;

    assign load    = head_valid && (!m_tvalid_reg || m_tready);
    // release goes first when the command carries one
    assign use_ev0 = head_cmd.ev0_valid && !phase_reg;
    assign pop     = load && !(use_ev0 && head_cmd.ev1_valid);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = key_reg;
    assign m_tuser  = down_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                phase_reg    <= use_ev0 && head_cmd.ev1_valid;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= use_ev0 ? head_cmd.ev0_key  : head_cmd.ev1_key;
            down_reg <= use_ev0 ? head_cmd.ev0_down : head_cmd.ev1_down;
            last_reg <= use_ev0 ? !head_cmd.ev1_valid : 1'b1;
        end
    end

endmodule

FILE: design/gkm_checker.sv
module gkm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output item changed");

    // the first of a pair is always a release
    a_pair_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser)
        else $error("first event of a pair is not a release");

    // only axis changes give pairs, and they use arrow keys
    a_pair_arrow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata == gkm_pkg::KC_UP
                                  || m_tdata == gkm_pkg::KC_DOWN
                                  || m_tdata == gkm_pkg::KC_LEFT
                                  || m_tdata == gkm_pkg::KC_RIGHT))
        else $error("paired event on a non-arrow key");

    // the press follows the release in the next cycle
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser && m_tlast)
        else $error("release not followed by the closing press");

endmodule

bind gamepad_to_key_event_mapper gkm_checker u_gkm_checker (.*);

FILE: verif/gamepad_to_key_event_mapper_test.sv
`timescale 1ns / 100ps

module gamepad_to_key_event_mapper_test;

    localparam int SETTLE_CYCLES = 12;

    // event types the block ignores
    localparam logic [4:0] EV_SYN      = 5'd0;
    localparam logic [4:0] EV_REL      = 5'd2;
    localparam logic [4:0] EV_TYPE_MAX = 5'd31;

    // button and axis codes used by the stimulus
    localparam logic [9:0] AXIS_Z          = 10'h002;
    localparam logic [9:0] BTN_BELOW       = 10'h0ff;
    localparam logic [9:0] BTN_A           = 10'h130;
    localparam logic [9:0] BTN_B           = 10'h131;
    localparam logic [9:0] BTN_SEL         = 10'h13a;
    localparam logic [9:0] BTN_TABLE_FIRST = 10'h120;
    localparam logic [9:0] BTN_TABLE_LAST  = 10'h13b;
    localparam logic [9:0] CODE_MAX        = 10'h2ff;

    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef enum {RX_FULL, RX_RANDOM, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        logic [7:0] key;
        logic       down;
        logic       last;
    } key_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // event_type[4:0], event_code[14:5], event_value[46:15]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // key_code[7:0]
    logic        m_tuser;        // down[0]
    logic        m_tlast;        // last_of_run

    // predictor state
    logic signed [31:0] range_reg [gkm_pkg::NUM_SLOTS];
    logic [1:0]         axis_dir [gkm_pkg::NUM_SLOTS];
    key_event_t         pending_keys [$];

    int       mismatches = 0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_FULL;

    gamepad_to_key_event_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] button_to_key(logic [9:0] code);
        case (code)
            10'h130: return gkm_pkg::KC_ENTER;
            10'h131: return gkm_pkg::KC_ESC;
            10'h133: return gkm_pkg::KC_Z;
            10'h134: return gkm_pkg::KC_X;
            10'h136: return gkm_pkg::KC_LSHIFT;
            10'h137: return gkm_pkg::KC_C;
            10'h13a: return gkm_pkg::KC_BACKSPACE;
            10'h13b: return gkm_pkg::KC_ENTER;
            10'h120: return gkm_pkg::KC_ENTER;
            10'h121: return gkm_pkg::KC_Z;
            10'h122: return gkm_pkg::KC_X;
            10'h123: return gkm_pkg::KC_ESC;
            10'h124: return gkm_pkg::KC_ENTER;
            10'h125: return gkm_pkg::KC_Z;
            10'h126: return gkm_pkg::KC_ENTER;
            10'h127: return gkm_pkg::KC_ESC;
            10'h128: return gkm_pkg::KC_LSHIFT;
            10'h129: return gkm_pkg::KC_C;
            10'h12a: return gkm_pkg::KC_BACKSPACE;
            10'h12b: return gkm_pkg::KC_ENTER;
            default: return gkm_pkg::KC_ENTER;
        endcase
    endfunction

    function automatic int slot_of(logic [9:0] code);
        case (code)
            gkm_pkg::AXIS_X:     return int'(gkm_pkg::SLOT_X);
            gkm_pkg::AXIS_Y:     return int'(gkm_pkg::SLOT_Y);
            gkm_pkg::AXIS_RX:    return int'(gkm_pkg::SLOT_RX);
            gkm_pkg::AXIS_RY:    return int'(gkm_pkg::SLOT_RY);
            gkm_pkg::AXIS_HAT_X: return int'(gkm_pkg::SLOT_HAT0X);
            gkm_pkg::AXIS_HAT_Y: return int'(gkm_pkg::SLOT_HAT0Y);
            default:             return -1;
        endcase
    endfunction

    function automatic int pair_of(int slot);
        return (slot >= int'(gkm_pkg::SLOT_HAT0X)) ? 2
             : ((slot >= int'(gkm_pkg::SLOT_RX)) ? 1 : 0);
    endfunction

    // zone edges at full precision; a reversed range gives a negative span
    function automatic void zone_edges(int pair, output longint neg_edge,
                                       output longint pos_edge);
        longint lo, hi, mid, span;
        lo = range_reg[2 * pair];
        hi = range_reg[2 * pair + 1];
        mid = (lo + hi) / 2;
        span = hi - lo;
        if (span == 0)
            span = 255;
        neg_edge = mid - span / 4;
        pos_edge = mid + span / 4;
    endfunction

    function automatic void map_event(logic [4:0] ev_type, logic [9:0] code,
                                      logic signed [31:0] value);
        int         slot;
        longint     v, neg_edge, pos_edge;
        logic [1:0] dir, old;
        logic [7:0] key_neg, key_pos;
        logic       has_rel, has_prs;
        v = value;
        if (ev_type == gkm_pkg::EV_KEY)
        begin
            if (code >= gkm_pkg::BTN_BASE && (v == 0 || v == 1))
                pending_keys.push_back(key_event_t'{button_to_key(code), v[0], 1'b1});
            return;
        end
        if (ev_type != gkm_pkg::EV_ABS)
            return;
        slot = slot_of(code);
        if (slot < 0)
            return;
        zone_edges(pair_of(slot), neg_edge, pos_edge);
        if (v <= neg_edge)
            dir = gkm_pkg::DIR_NEG;
        else if (v >= pos_edge)
            dir = gkm_pkg::DIR_POS;
        else
            dir = gkm_pkg::DIR_CENTRE;
        if (slot == int'(gkm_pkg::SLOT_X) || slot == int'(gkm_pkg::SLOT_RX)
            || slot == int'(gkm_pkg::SLOT_HAT0X))
        begin
            key_neg = gkm_pkg::KC_LEFT;
            key_pos = gkm_pkg::KC_RIGHT;
        end
        else
        begin
            key_neg = gkm_pkg::KC_UP;
            key_pos = gkm_pkg::KC_DOWN;
        end
        old = axis_dir[slot];
        if (dir == old)
            return;
        has_rel = (old != gkm_pkg::DIR_CENTRE);
        has_prs = (dir != gkm_pkg::DIR_CENTRE);
        // release of the old direction comes first
        if (has_rel)
            pending_keys.push_back(key_event_t'{
                (old == gkm_pkg::DIR_NEG) ? key_neg : key_pos, 1'b0, !has_prs});
        if (has_prs)
            pending_keys.push_back(key_event_t'{
                (dir == gkm_pkg::DIR_NEG) ? key_neg : key_pos, 1'b1, 1'b1});
        axis_dir[slot] = dir;
    endfunction

    function automatic logic [31:0] clamp_value(longint x);
        if (x < INT_MIN)
            return INT_MIN;
        if (x > INT_MAX)
            return INT_MAX;
        return x[31:0];
    endfunction

    // mostly readings on or next to a zone edge, so that directions keep changing
    function automatic logic [31:0] pick_axis_value(int slot);
        longint neg_edge, pos_edge, pick;
        zone_edges(pair_of(slot), neg_edge, pos_edge);
        case ($urandom_range(0, 9))
            0:       pick = neg_edge;
            1:       pick = neg_edge + 1;
            2:       pick = neg_edge - 1;
            3:       pick = pos_edge;
            4:       pick = pos_edge - 1;
            5:       pick = pos_edge + 1;
            6:       pick = (neg_edge + pos_edge) / 2;
            7:       pick = INT_MIN;
            8:       pick = INT_MAX;
            default: pick = int'($urandom());
        endcase
        return clamp_value(pick);
    endfunction

    function automatic logic [9:0] random_axis_code();
        case ($urandom_range(0, 5))
            0:       return gkm_pkg::AXIS_X;
            1:       return gkm_pkg::AXIS_Y;
            2:       return gkm_pkg::AXIS_RX;
            3:       return gkm_pkg::AXIS_RY;
            4:       return gkm_pkg::AXIS_HAT_X;
            default: return gkm_pkg::AXIS_HAT_Y;
        endcase
    endfunction

    // hold the item until accepted, then predict its key events
    task automatic send_event(logic [4:0] ev_type, logic [9:0] code, logic [31:0] value);
        @(negedge clk);
        s_tdata = {1'b0, value, code, ev_type};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        map_event(ev_type, code, value);
    endtask

    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // drain every expected key event, then let items with no result leave the pipe
    task automatic wait_idle();
        pause_sender(1);
        while (pending_keys.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_index = index;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index < gkm_pkg::NUM_SLOTS)
            range_reg[index] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_axis();
        logic [9:0] code;
        code = random_axis_code();
        send_event(gkm_pkg::EV_ABS, code, pick_axis_value(slot_of(code)));
    endtask

    task automatic send_random_event();
        int          roll;
        logic [9:0]  code;
        logic [31:0] value;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            if ($urandom_range(0, 9) < 7)
                code = 10'($urandom_range(BTN_TABLE_FIRST, BTN_TABLE_LAST));
            else
                code = 10'($urandom_range(gkm_pkg::BTN_BASE, CODE_MAX));
            case ($urandom_range(0, 9))
                8:       value = 32'd2;
                9:       value = $urandom();
                default: value = $urandom_range(0, 1);
            endcase
            send_event(gkm_pkg::EV_KEY, code, value);
        end
        else if (roll < 88)
            send_random_axis();
        else
            send_event(5'($urandom_range(0, EV_TYPE_MAX)),
                       10'($urandom_range(0, CODE_MAX)), $urandom());
    endtask

    task automatic set_random_ranges();
        int         center, half;
        logic [2:0] idx;
        for (int p = 0; p < 3; p++)
        begin
            idx = gkm_pkg::REG_LEFT_MIN + 3'(2 * p);
            center = $urandom_range(0, 2000) - 1000;
            half = $urandom_range(0, 300);
            case ($urandom_range(0, 4))
                0:
                begin
                    write_reg(idx, $urandom());
                    write_reg(idx + 3'd1, $urandom());
                end
                1:
                begin
                    write_reg(idx, center + half);
                    write_reg(idx + 3'd1, center - half);
                end
                2:
                begin
                    write_reg(idx, center);
                    write_reg(idx + 3'd1, center);
                end
                default:
                begin
                    write_reg(idx, center - half);
                    write_reg(idx + 3'd1, center + half);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());
    endtask

    task automatic test_buttons();
        send_event(gkm_pkg::EV_KEY, BTN_A, 32'd1);
        send_event(gkm_pkg::EV_KEY, BTN_A, 32'd0);
        send_event(gkm_pkg::EV_KEY, BTN_SEL, 32'd1);
        send_event(gkm_pkg::EV_KEY, BTN_TABLE_LAST, 32'd1);
        send_event(gkm_pkg::EV_KEY, gkm_pkg::BTN_BASE, 32'd1);
        send_event(gkm_pkg::EV_KEY, CODE_MAX, 32'd0);
        send_event(gkm_pkg::EV_KEY, BTN_BELOW, 32'd1);
        send_event(gkm_pkg::EV_KEY, BTN_B, 32'd2);
        send_event(gkm_pkg::EV_KEY, BTN_B, 32'hffff_ffff);
        send_event(gkm_pkg::EV_KEY, BTN_B, INT_MIN);
        send_event(gkm_pkg::EV_KEY, BTN_B, INT_MAX);
        send_event(EV_SYN, BTN_A, 32'd1);
        send_event(EV_TYPE_MAX, BTN_B, 32'd1);
        send_event(EV_REL, gkm_pkg::AXIS_X, INT_MIN);
    endtask

    // exact zone edges at the reset ranges, extreme values and unmapped axis codes
    task automatic test_axis_zones();
        longint neg_edge, pos_edge;
        zone_edges(0, neg_edge, pos_edge);
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, clamp_value(neg_edge));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, clamp_value(neg_edge + 1));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, clamp_value(pos_edge));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, clamp_value(neg_edge));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, clamp_value(pos_edge - 1));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, clamp_value(pos_edge - 1));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_Y, INT_MIN);
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_Y, INT_MAX);
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_RX, INT_MAX);
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_RY, clamp_value(neg_edge));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_HAT_X, clamp_value(pos_edge));
        send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_HAT_Y, clamp_value(pos_edge));
        send_event(gkm_pkg::EV_ABS, AXIS_Z, 32'd0);
        send_event(gkm_pkg::EV_ABS, CODE_MAX, INT_MIN);
    endtask

    // reversed, empty and full-scale ranges, plus writes to unused indexes
    task automatic test_range_extremes();
        wait_idle();
        write_reg(gkm_pkg::REG_LEFT_MIN, 32'd300);
        write_reg(gkm_pkg::REG_LEFT_MAX, -32'sd100);
        write_reg(gkm_pkg::REG_RIGHT_MIN, 32'd50);
        write_reg(gkm_pkg::REG_RIGHT_MAX, 32'd50);
        write_reg(gkm_pkg::REG_HAT_MIN, INT_MIN);
        write_reg(gkm_pkg::REG_HAT_MAX, INT_MAX);
        write_reg(REG_UNUSED_LO, $urandom());
        write_reg(REG_UNUSED_HI, 32'hffff_ffff);
        repeat (40) send_random_axis();
        wait_idle();
        write_reg(gkm_pkg::REG_LEFT_MIN, INT_MAX);
        write_reg(gkm_pkg::REG_LEFT_MAX, INT_MIN);
        write_reg(gkm_pkg::REG_RIGHT_MIN, INT_MIN);
        write_reg(gkm_pkg::REG_RIGHT_MAX, INT_MIN);
        write_reg(gkm_pkg::REG_HAT_MIN, INT_MAX);
        write_reg(gkm_pkg::REG_HAT_MAX, INT_MAX);
        write_reg(REG_UNUSED_HI, 32'd0);
        repeat (40) send_random_axis();
    endtask

    // receiver holds off while X swings end to end, so the queue fills and stalls input
    task automatic test_backpressure();
        wait_idle();
        write_reg(gkm_pkg::REG_LEFT_MIN, 32'd0);
        write_reg(gkm_pkg::REG_LEFT_MAX, 32'd255);
        rx_mode = RX_FULL;
        hold_left = 300;
        for (int i = 0; i < 40; i++)
            send_event(gkm_pkg::EV_ABS, gkm_pkg::AXIS_X, (i % 2) ? 32'd255 : 32'd0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int sent;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            set_random_ranges();
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            sent = 0;
            while (sent < 115)
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_mode = rx_mode_t'($urandom_range(0, 2));
                repeat ($urandom_range(1, 12))
                begin
                    send_random_event();
                    sent++;
                end
                pause_sender($urandom_range(0, 5));
            end
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            case (rx_mode)
                RX_FULL:   m_tready = 1'b1;
                RX_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
                default:   m_tready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        key_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_keys.size() == 0)
            begin
                $display("%0t: unexpected key event: key %0d down %0b last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_keys.pop_front();
                if (m_tdata !== want.key)
                begin
                    $display("%0t: key_code mismatch: expected %0d, actual %0d",
                             $time, want.key, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.down)
                begin
                    $display("%0t: down flag mismatch: expected %0b, actual %0b",
                             $time, want.down, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("gamepad_to_key_event_mapper_test: FAIL");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < gkm_pkg::NUM_SLOTS; i++)
        begin
            range_reg[i] = (i % 2) ? 32'sd255 : 32'sd0;
            axis_dir[i] = gkm_pkg::DIR_CENTRE;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_buttons();
        test_axis_zones();
        test_range_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (mismatches == 0)
            $display("gamepad_to_key_event_mapper_test: PASS");
        else
            $display("gamepad_to_key_event_mapper_test: FAIL");
        $finish;
    end

endmodule
